>>> rtl/jca_pkg.sv
package jca_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int ETA_W      = 7;
    localparam int PHI_W      = 7;
    localparam int E_IN_W     = 8;
    localparam int SIZE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = 16;
    localparam int TOT_W      = 17;
    localparam int ASYM_W     = 18;
    localparam int CNT_W      = 9;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 96;

    // Output beat layout, lowest bit of each field
    localparam int M_ECAL_LSB  = STATUS_W;
    localparam int M_HCAL_LSB  = M_ECAL_LSB + SUM_W;
    localparam int M_TOT_LSB   = M_HCAL_LSB + SUM_W;
    localparam int M_ETA_LSB   = M_TOT_LSB + TOT_W;
    localparam int M_PHI_LSB   = M_ETA_LSB + ASYM_W;
    localparam int M_CNT_LSB   = M_PHI_LSB + ASYM_W;

    // Beyond this |eta| the eta half point sits one tower past the corner
    localparam int HF_ETA_EDGE = 28;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_JET_ETA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JET_PHI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JET_SIZE = 2'd2;

    // Operations
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd3;

    // Direction of an asymmetry update; both clear means no change
    typedef struct packed {
        logic plus;
        logic minus;
    } sign_t;

endpackage

>>> rtl/jet_constituent_asymmetry_accumulator.sv
// An accepted beat is registered in stage 1, then its result in the output register.
// Throughput: one tower per cycle while the output is not stalled; each beat is one
// read-modify-write of the slot memories, forwarded when consecutive beats share a slot.
// Reset: asynchronous, active low; sums, count and config go to their reset values,
// then a clearing pass over all MAX_WINDOW*MAX_WINDOW slots (256 by default) empties the
// presence memory while s_axis_tready is held low. Config writes are taken meanwhile.
module jet_constituent_asymmetry_accumulator #(
    parameter int MAX_WINDOW  = 16,
    parameter int ENERGY_BITS = 8,
    parameter int PHI_TOWERS  = 72
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [jca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jca_pkg::CFG_DATA_W-1:0]  cfg_data,
    // tower input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tower_eta[6:0], tower_phi[13:7], ecal_energy[21:14], hcal_energy[29:22], zero[31:30]
    input  logic [jca_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  logic [0:0]                      s_axis_tuser,
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], ecal_total[17:2], hcal_total[33:18], energy_total[50:34],
    // eta_asymmetry[68:51], phi_asymmetry[86:69], member_count[95:87]
    output logic [jca_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import jca_pkg::*;

    localparam int SLOTS  = MAX_WINDOW * MAX_WINDOW;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int EB     = (ENERGY_BITS < E_IN_W) ? ENERGY_BITS : E_IN_W;
    localparam int EFF_W  = SIZE_W + 1;
    localparam int CMP_W  = 10;

    localparam logic [SLOT_W-1:0]       SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic signed [CMP_W-1:0] PHI_C     = CMP_W'(PHI_TOWERS);
    localparam logic signed [CMP_W-1:0] HF_C      = CMP_W'(HF_ETA_EDGE);
    localparam logic signed [CMP_W-1:0] ONE_C     = CMP_W'(1);

    typedef struct packed {
        logic              op;
        logic              in_window;
        logic [SLOT_W-1:0] slot;
        logic [EB-1:0]     ecal;
        logic [EB-1:0]     hcal;
        sign_t             eta_sgn;
        sign_t             phi_sgn;
    } item_t;

    // configuration
    logic signed [ETA_W-1:0] jet_eta_reg;
    logic [PHI_W-1:0]        jet_phi_reg;
    logic [SIZE_W-1:0]       jet_size_reg;

    // clearing pass
    logic              clr_active_reg;
    logic [SLOT_W-1:0] clr_addr_reg;

    // slot memories and their read registers
    logic [2*EB-1:0] energy_mem [SLOTS];
    logic            present_mem [SLOTS];
    logic [2*EB-1:0] energy_rd_reg;
    logic            present_rd_reg;

    // stage 1 and forwarding
    logic            s1_valid_reg;
    item_t           s1_item_reg;
    logic            fwd_hit_reg;
    logic            fwd_present_reg;
    logic [2*EB-1:0] fwd_energy_reg;

    // accumulators
    logic [SUM_W-1:0]         ecal_acc_reg, ecal_acc_next;
    logic [SUM_W-1:0]         hcal_acc_reg, hcal_acc_next;
    logic [ASYM_W-1:0]        eta_bal_reg, eta_bal_next;
    logic [ASYM_W-1:0]        phi_bal_reg, phi_bal_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    // output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // stage 0 signals
    logic                    s_acc;
    logic                    s1_adv;
    item_t                   item_in;
    logic signed [ETA_W-1:0] t_eta;
    logic [PHI_W-1:0]        t_phi;
    logic [EFF_W-1:0]        size_eff;
    logic signed [CMP_W-1:0] eta_x, jeta_x, phi_x, jphi_x, size_x;
    logic signed [CMP_W-1:0] de, dp_raw, dp, eta_half, phi_half;
    logic signed [CMP_W-1:0] eta_mid, phi_mid, phi_u;
    logic                    odd_size;
    sign_t                   eta_sgn_add, phi_sgn_add;

    // stage 1 signals
    logic              present_cur;
    logic [2*EB-1:0]   energy_cur;
    logic [EB-1:0]     ecal_eff, hcal_eff;
    logic [EB:0]       e_sum;
    logic              do_it;
    logic [STATUS_W-1:0] status;
    logic [TOT_W-1:0]  total_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jet_eta_reg  <= '0;
            jet_phi_reg  <= PHI_W'(1);
            jet_size_reg <= SIZE_W'(12);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_JET_ETA:  jet_eta_reg  <= cfg_data[ETA_W-1:0];
                REG_JET_PHI:  jet_phi_reg  <= cfg_data[PHI_W-1:0];
                REG_JET_SIZE: jet_size_reg <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // clearing pass over the presence memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == SLOT_LAST)
                clr_active_reg <= 1'b0;
            clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
        end
    end

    // handshake
    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // stage 0: window test, slot and asymmetry signs
    always_comb
    begin
        t_eta    = s_axis_tdata[ETA_W-1:0];
        t_phi    = s_axis_tdata[ETA_W+PHI_W-1:ETA_W];
        size_eff = (jet_size_reg > MAX_WINDOW) ? EFF_W'(MAX_WINDOW) : {1'b0, jet_size_reg};
        odd_size = size_eff[0];

        eta_x  = {{(CMP_W-ETA_W){t_eta[ETA_W-1]}}, t_eta};
        jeta_x = {{(CMP_W-ETA_W){jet_eta_reg[ETA_W-1]}}, jet_eta_reg};
        phi_x  = {{(CMP_W-PHI_W){1'b0}}, t_phi};
        jphi_x = {{(CMP_W-PHI_W){1'b0}}, jet_phi_reg};
        size_x = {{(CMP_W-EFF_W){1'b0}}, size_eff};

        de     = eta_x - jeta_x;
        dp_raw = phi_x - jphi_x;
        dp     = (dp_raw < 0) ? dp_raw + PHI_C : dp_raw;

        item_in.op        = s_axis_tuser[0];
        item_in.in_window = (size_eff != '0) && (de >= 0) && (de < size_x)
                            && (dp >= 0) && (dp < size_x);
        item_in.slot      = item_in.in_window ? SLOT_W'(de * MAX_WINDOW + dp) : '0;
        item_in.ecal      = s_axis_tdata[ETA_W+PHI_W+EB-1:ETA_W+PHI_W];
        item_in.hcal      = s_axis_tdata[ETA_W+PHI_W+E_IN_W+EB-1:ETA_W+PHI_W+E_IN_W];

        // eta half point, fixed at one tower in the forward region
        eta_half = ((jeta_x > HF_C) || (jeta_x < -HF_C)) ? ONE_C : (size_x >>> 1);
        eta_mid  = jeta_x + eta_half;
        eta_sgn_add.plus  = odd_size ? (eta_x > eta_mid) : (eta_x >= eta_mid);
        eta_sgn_add.minus = eta_x < eta_mid;

        // phi unwrapped across the ring edge
        phi_half = size_x >>> 1;
        phi_mid  = jphi_x + phi_half;
        phi_u    = ((jphi_x > PHI_C - size_x) && (phi_x < size_x)) ? phi_x + PHI_C : phi_x;
        phi_sgn_add.plus  = phi_u < phi_mid;
        phi_sgn_add.minus = odd_size ? (phi_u > phi_mid) : (phi_u >= phi_mid);

        // remove applies the opposite sign
        if (item_in.op == OP_REMOVE)
        begin
            item_in.eta_sgn = '{plus: eta_sgn_add.minus, minus: eta_sgn_add.plus};
            item_in.phi_sgn = '{plus: phi_sgn_add.minus, minus: phi_sgn_add.plus};
        end
        else
        begin
            item_in.eta_sgn = eta_sgn_add;
            item_in.phi_sgn = phi_sgn_add;
        end
    end

    // stage 1: combine read data with forwarded write, update sums
    always_comb
    begin
        present_cur = fwd_hit_reg ? fwd_present_reg : present_rd_reg;
        energy_cur  = fwd_hit_reg ? fwd_energy_reg : energy_rd_reg;

        if (s1_item_reg.op == OP_ADD)
        begin
            ecal_eff = s1_item_reg.ecal;
            hcal_eff = s1_item_reg.hcal;
            if (!s1_item_reg.in_window)
                status = ST_OUTSIDE;
            else if (present_cur)
                status = ST_PRESENT;
            else
                status = ST_DONE;
        end
        else
        begin
            ecal_eff = energy_cur[EB-1:0];
            hcal_eff = energy_cur[2*EB-1:EB];
            status   = (s1_item_reg.in_window && present_cur) ? ST_DONE : ST_NOT_FOUND;
        end
        do_it = (status == ST_DONE);
        e_sum = {1'b0, ecal_eff} + {1'b0, hcal_eff};

        ecal_acc_next = ecal_acc_reg;
        hcal_acc_next = hcal_acc_reg;
        count_next    = count_reg;
        eta_bal_next  = eta_bal_reg;
        phi_bal_next  = phi_bal_reg;
        if (do_it)
        begin
            if (s1_item_reg.op == OP_ADD)
            begin
                ecal_acc_next = ecal_acc_reg + SUM_W'(ecal_eff);
                hcal_acc_next = hcal_acc_reg + SUM_W'(hcal_eff);
                count_next    = count_reg + CNT_W'(1);
            end
            else
            begin
                ecal_acc_next = ecal_acc_reg - SUM_W'(ecal_eff);
                hcal_acc_next = hcal_acc_reg - SUM_W'(hcal_eff);
                count_next    = count_reg - CNT_W'(1);
            end
            if (s1_item_reg.eta_sgn.plus)
                eta_bal_next = eta_bal_reg + ASYM_W'(e_sum);
            else if (s1_item_reg.eta_sgn.minus)
                eta_bal_next = eta_bal_reg - ASYM_W'(e_sum);
            if (s1_item_reg.phi_sgn.plus)
                phi_bal_next = phi_bal_reg + ASYM_W'(e_sum);
            else if (s1_item_reg.phi_sgn.minus)
                phi_bal_next = phi_bal_reg - ASYM_W'(e_sum);
        end
        total_next = TOT_W'(ecal_acc_next) + TOT_W'(hcal_acc_next);
    end

    // energy memory: read on accept, written by a completed add
    always_ff @(posedge clk)
    begin
        if (s_acc)
            energy_rd_reg <= energy_mem[item_in.slot];
        if (s1_adv && do_it && (s1_item_reg.op == OP_ADD))
            energy_mem[s1_item_reg.slot] <= {s1_item_reg.hcal, s1_item_reg.ecal};
    end

    // presence memory: cleared after reset, set by add, cleared by remove
    always_ff @(posedge clk)
    begin
        if (s_acc)
            present_rd_reg <= present_mem[item_in.slot];
        if (clr_active_reg)
            present_mem[clr_addr_reg] <= 1'b0;
        else if (s1_adv && do_it)
            present_mem[s1_item_reg.slot] <= (s1_item_reg.op == OP_ADD);
    end

    // stage 1 payload and forwarding of the write issued in the same cycle
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_item_reg     <= item_in;
            fwd_present_reg <= (s1_item_reg.op == OP_ADD);
            fwd_energy_reg  <= {s1_item_reg.hcal, s1_item_reg.ecal};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_adv && do_it && (item_in.slot == s1_item_reg.slot);
            end
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecal_acc_reg <= '0;
            hcal_acc_reg <= '0;
            eta_bal_reg  <= '0;
            phi_bal_reg  <= '0;
            count_reg    <= '0;
        end
        else if (s1_adv)
        begin
            ecal_acc_reg <= ecal_acc_next;
            hcal_acc_reg <= hcal_acc_next;
            eta_bal_reg  <= eta_bal_next;
            phi_bal_reg  <= phi_bal_next;
            count_reg    <= count_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s1_adv)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            m_data_reg <= {count_next, phi_bal_next, eta_bal_next, total_next,
                           hcal_acc_next, ecal_acc_next, status};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> rtl/jca_checker.sv
module jca_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [jca_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import jca_pkg::*;

    logic                m_beat;
    logic [STATUS_W-1:0] status;
    logic [SUM_W-1:0]    ecal_total, hcal_total;
    logic [TOT_W-1:0]    energy_total;
    logic [CNT_W-1:0]    member_count;
    logic [CNT_W-1:0]    prev_count_reg;

    assign m_beat       = m_axis_tvalid && m_axis_tready;
    assign status       = m_axis_tdata[STATUS_W-1:0];
    assign ecal_total   = m_axis_tdata[M_ECAL_LSB+SUM_W-1:M_ECAL_LSB];
    assign hcal_total   = m_axis_tdata[M_HCAL_LSB+SUM_W-1:M_HCAL_LSB];
    assign energy_total = m_axis_tdata[M_TOT_LSB+TOT_W-1:M_TOT_LSB];
    assign member_count = m_axis_tdata[M_CNT_LSB+CNT_W-1:M_CNT_LSB];

    // member count seen on the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_count_reg <= '0;
        else if (m_beat)
            prev_count_reg <= member_count;
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // total is the sum of both partial sums
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> energy_total == (TOT_W'(ecal_total) + TOT_W'(hcal_total)))
        else $error("energy total does not match ecal plus hcal");

    // an empty jet carries no energy
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (member_count == '0) |-> (ecal_total == '0) && (hcal_total == '0))
        else $error("empty jet with nonzero energy");

    // a refused tower leaves the member count alone
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat && (status != ST_DONE) |-> member_count == prev_count_reg)
        else $error("refused tower changed the member count");

    // an accepted tower moves the member count by one
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat && (status == ST_DONE) |->
            (member_count == prev_count_reg + CNT_W'(1))
            || (member_count == prev_count_reg - CNT_W'(1)))
        else $error("member count did not move by one");

endmodule

bind jet_constituent_asymmetry_accumulator jca_checker u_jca_checker (.*);
